FILE: src/s2cd_pkg.sv
// Shared widths, conversion constants and the month start table for the
// seconds-to-calendar-date block. No dependencies.
package s2cd_pkg;

  // Pipeline depth in register stages
  localparam int NSTG = 6;

  // Field widths
  localparam int SECS_W  = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;

  // Internal widths
  localparam int DAYQ_W  = 16;  // whole days, up to 49710
  localparam int DREM_W  = 17;  // seconds within the day
  localparam int YNUM_W  = 18;  // 4*days+3
  localparam int YIDX_W  = 8;   // years since 1976
  localparam int MINS_W  = 11;  // minutes within the day
  localparam int DOY_W   = 9;   // day within March-based year
  localparam int MIDX_W  = 4;   // month index, 0 = March

  // Calendar constants
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [15:0] DAY_SHIFT    = 16'd671;
  localparam logic [10:0] FOUR_YR_DAYS = 11'd1461;
  localparam logic [11:0] BASE_YEAR    = 12'd1976;
  localparam logic [5:0]  MINS_PER_HR  = 6'd60;

  // Reciprocals (rounded up), exact over the ranges used here
  // secs>>7 / 675 : scale 2^35
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // n / 1461 : scale 2^32
  localparam logic [21:0] YEAR_RECIP = 22'd2939745;
  // r / 60 : scale 2^23
  localparam logic [17:0] MIN_RECIP  = 18'd139811;
  // m / 60 : scale 2^17
  localparam logic [11:0] HR_RECIP   = 12'd2185;
  // n / 153 : scale 2^20
  localparam logic [12:0] MON_RECIP  = 13'd6854;

  // Month index at which the calendar year wraps (January)
  localparam logic [MIDX_W-1:0] MIDX_JAN = 4'd10;

  // First day of each month within a March-based year
  function automatic logic [DOY_W-1:0] month_base(input logic [MIDX_W-1:0] midx);
    logic [DOY_W-1:0] base;
    case (midx)
      4'd0:    base = 9'd0;    // Mar
      4'd1:    base = 9'd31;   // Apr
      4'd2:    base = 9'd61;   // May
      4'd3:    base = 9'd92;   // Jun
      4'd4:    base = 9'd122;  // Jul
      4'd5:    base = 9'd153;  // Aug
      4'd6:    base = 9'd184;  // Sep
      4'd7:    base = 9'd214;  // Oct
      4'd8:    base = 9'd245;  // Nov
      4'd9:    base = 9'd275;  // Dec
      4'd10:   base = 9'd306;  // Jan
      4'd11:   base = 9'd337;  // Feb
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

FILE: src/seconds_to_calendar_date.sv
// Seconds-to-calendar-date converter, top level: handshake and stage valids.
// Depends on s2cd_pkg and s2cd_datapath.
//
// Usage
//   Input word : in_seconds_count, seconds since 1978-01-01 00:00, taken
//                on in_valid & in_ready.
//   Output word: year, month, day of month, hour and minute, offered on
//                out_valid and taken on out_valid & out_ready.
//   Pipeline   : six register stages; a word taken in passes through all
//                six in order before it is offered on out_valid.
//   Throughput : one word per cycle while out_ready is high.
//   Stall      : a stage holds while it is full and the stage after it
//                cannot move; bubbles are squeezed out, so in_ready drops
//                only when all six stages hold a word and out_ready is low.
//   Reset      : rst_n (synchronous, active low) empties the pipeline.
//   Calendar   : every fourth year is a leap year, 2100 included.
module seconds_to_calendar_date (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [s2cd_pkg::SECS_W-1:0]   in_seconds_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [s2cd_pkg::YEAR_W-1:0]   out_year,
  output logic [s2cd_pkg::MONTH_W-1:0]  out_month,
  output logic [s2cd_pkg::DOM_W-1:0]    out_day_of_month,
  output logic [s2cd_pkg::HOUR_W-1:0]   out_hour,
  output logic [s2cd_pkg::MIN_W-1:0]    out_minute
);
  import s2cd_pkg::*;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] stg_en;

  // Stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    stg_en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    vld_nxt[0] = stg_en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = stg_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[NSTG-1];

  // Payload path
  s2cd_datapath u_dp (
    .clk          (clk),
    .stg_en       (stg_en),
    .secs_in      (in_seconds_count),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month),
    .hour         (out_hour),
    .minute       (out_minute)
  );

endmodule

FILE: src/s2cd_datapath.sv
// Six-stage payload path of the seconds-to-calendar-date block: day split,
// four-year cycle, five-month cycle and hour/minute split. Uses s2cd_pkg.
module s2cd_datapath (
  input  logic                          clk,
  input  logic [s2cd_pkg::NSTG-1:0]     stg_en,
  input  logic [s2cd_pkg::SECS_W-1:0]   secs_in,
  output logic [s2cd_pkg::YEAR_W-1:0]   year,
  output logic [s2cd_pkg::MONTH_W-1:0]  month,
  output logic [s2cd_pkg::DOM_W-1:0]    day_of_month,
  output logic [s2cd_pkg::HOUR_W-1:0]   hour,
  output logic [s2cd_pkg::MIN_W-1:0]    minute
);
  import s2cd_pkg::*;

  // ---- stage 1: whole days by reciprocal multiply --------------------
  logic [50:0]         dprod;
  logic [DAYQ_W-1:0]   q1_nxt, q1_r;
  logic [SECS_W-1:0]   secs1_r;

  assign dprod  = secs_in[SECS_W-1:7] * DAY_RECIP;
  assign q1_nxt = dprod[50:35];

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      q1_r    <= q1_nxt;
      secs1_r <= secs_in;
    end
  end

  // ---- stage 2: seconds within day, year numerator -------------------
  logic [32:0]         qsec;
  logic [SECS_W-1:0]   rem_full;
  logic [DAYQ_W-1:0]   days_sh;
  logic [DREM_W-1:0]   rem2_nxt, rem2_r;
  logic [YNUM_W-1:0]   n2_nxt, n2_r;

  assign qsec     = q1_r * SECS_PER_DAY;
  assign rem_full = secs1_r - qsec[SECS_W-1:0];
  assign rem2_nxt = rem_full[DREM_W-1:0];
  assign days_sh  = q1_r + DAY_SHIFT;         // days since 1976-03-01
  assign n2_nxt   = {days_sh, 2'b11};         // 4*days + 3

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      rem2_r <= rem2_nxt;
      n2_r   <= n2_nxt;
    end
  end

  // ---- stage 3: year index and minutes of day ------------------------
  logic [39:0]         yprod;
  logic [34:0]         mprod;
  logic [YIDX_W-1:0]   y3_nxt, y3_r;
  logic [MINS_W-1:0]   mins3_nxt, mins3_r;
  logic [YNUM_W-1:0]   n3_r;

  assign yprod     = n2_r * YEAR_RECIP;
  assign y3_nxt    = yprod[39:32];
  assign mprod     = rem2_r * MIN_RECIP;
  assign mins3_nxt = mprod[33:23];

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      y3_r    <= y3_nxt;
      n3_r    <= n2_r;
      mins3_r <= mins3_nxt;
    end
  end

  // ---- stage 4: day of year, hour ------------------------------------
  // 4*days+3 - 1461*y leaves 4*doy plus a 0..3 offset, so doy = rem >> 2
  logic [18:0]         y1461;
  logic [YNUM_W-1:0]   yrem;
  logic [22:0]         hprod;
  logic [DOY_W-1:0]    d4_nxt, d4_r;
  logic [HOUR_W-1:0]   hr4_nxt, hr4_r;
  logic [YIDX_W-1:0]   y4_r;
  logic [MINS_W-1:0]   mins4_r;

  assign y1461   = y3_r * FOUR_YR_DAYS;
  assign yrem    = n3_r - y1461[YNUM_W-1:0];
  assign d4_nxt  = yrem[10:2];
  assign hprod   = mins3_r * HR_RECIP;
  assign hr4_nxt = hprod[21:17];

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      d4_r    <= d4_nxt;
      y4_r    <= y3_r;
      hr4_r   <= hr4_nxt;
      mins4_r <= mins3_r;
    end
  end

  // ---- stage 5: month index, minute ----------------------------------
  logic [10:0]         mnum;
  logic [23:0]         moprod;
  logic [10:0]         hr60;
  logic [MINS_W-1:0]   mleft;
  logic [MIDX_W-1:0]   mo5_nxt, mo5_r;
  logic [MIN_W-1:0]    min5_nxt, min5_r;
  logic [DOY_W-1:0]    d5_r;
  logic [YIDX_W-1:0]   y5_r;
  logic [HOUR_W-1:0]   hr5_r;

  assign mnum     = 11'(d4_r) * 11'd5 + 11'd2;
  assign moprod   = mnum * MON_RECIP;
  assign mo5_nxt  = moprod[23:20];
  assign hr60     = hr4_r * MINS_PER_HR;
  assign mleft    = mins4_r - hr60;
  assign min5_nxt = mleft[MIN_W-1:0];

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      mo5_r  <= mo5_nxt;
      min5_r <= min5_nxt;
      d5_r   <= d4_r;
      y5_r   <= y4_r;
      hr5_r  <= hr4_r;
    end
  end

  // ---- stage 6: day of month, month wrap, output register ------------
  logic [DOY_W-1:0]    dom_full;
  logic                wrap;
  logic [MONTH_W-1:0]  month_nxt;
  logic [YEAR_W-1:0]   year_nxt;

  assign dom_full  = d5_r - month_base(mo5_r) + 9'd1;
  assign wrap      = (mo5_r >= MIDX_JAN);
  assign month_nxt = wrap ? (mo5_r - 4'd9) : (mo5_r + 4'd3);
  assign year_nxt  = 12'(y5_r) + BASE_YEAR + 12'(wrap);

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      year         <= year_nxt;
      month        <= month_nxt;
      day_of_month <= dom_full[DOM_W-1:0];
      hour         <= hr5_r;
      minute       <= min5_r;
    end
  end

endmodule

FILE: src/s2cd_checker.sv
// Port-level checks for seconds_to_calendar_date, attached by bind.
// Depends on s2cd_pkg.
module s2cd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [s2cd_pkg::YEAR_W-1:0]   out_year,
  input logic [s2cd_pkg::MONTH_W-1:0]  out_month,
  input logic [s2cd_pkg::DOM_W-1:0]    out_day_of_month,
  input logic [s2cd_pkg::HOUR_W-1:0]   out_hour,
  input logic [s2cd_pkg::MIN_W-1:0]    out_minute
);
  import s2cd_pkg::*;

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day_of_month) && $stable(out_hour) && $stable(out_minute))
    else $error("result word changed while stalled");

  // A free-running receiver never back-pressures the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although output side is ready");

  // Month, hour and minute within their calendar ranges; day of month at least 1
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12
      && out_day_of_month >= 5'd1 && out_hour <= 5'd23 && out_minute <= 6'd59)
    else $error("date or time field out of range");

  a_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year >= 12'd1978 && out_year <= 12'd2114)
    else $error("year out of range");

  // Pipeline is empty straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for seconds_to_calendar_date: directed edge dates, then
// random timestamps with bursty idling on both sides. Depends on s2cd_pkg.
module tb_top;

  // Conversion constants for the date prediction
  localparam int unsigned DAY_SECS      = 86400;
  localparam int unsigned EPOCH_SHIFT   = 671;   // 1978-01-01 -> day count from 1976-03-01
  localparam int unsigned QUAD_DAYS     = 1461;
  localparam int unsigned PENTA_DAYS    = 153;
  localparam int unsigned FIRST_YEAR    = 1976;
  localparam int unsigned MONTHS_PER_YR = 12;
  localparam int unsigned MINS_PER_HOUR = 60;

  // Day numbers counted from 1978-01-01
  localparam int unsigned D_1978_FEB28 = 58;
  localparam int unsigned D_1978_DEC31 = 364;
  localparam int unsigned D_1980_FEB29 = 789;
  localparam int unsigned D_2100_JAN01 = 44560;
  localparam int unsigned D_2100_FEB29 = 44619;
  localparam int unsigned D_LAST_WHOLE = 49709;  // last day that ends inside 32 bits
  localparam int unsigned D_LAST       = 49710;

  localparam int N_RANDOM        = 826;
  localparam int N_QUIET         = 100;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic [s2cd_pkg::YEAR_W-1:0]  year;
    logic [s2cd_pkg::MONTH_W-1:0] month;
    logic [s2cd_pkg::DOM_W-1:0]   day_of_month;
    logic [s2cd_pkg::HOUR_W-1:0]  hour;
    logic [s2cd_pkg::MIN_W-1:0]   minute;
  } cal_date_t;

  // Holds the dates still owed by the block, oldest first
  class date_scoreboard;
    cal_date_t owed_dates[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Four-year-cycle calendar from a March-based epoch of 1976
    function cal_date_t predict_date(logic [31:0] secs);
      int unsigned days, yr, mo, dy, mins, hr, mn;
      cal_date_t   d;
      days = secs / DAY_SECS + EPOCH_SHIFT;
      yr   = (4 * days + 3) / QUAD_DAYS;
      days = days - (QUAD_DAYS * yr) / 4;
      yr   = yr + FIRST_YEAR;
      mo   = (5 * days + 2) / PENTA_DAYS;
      dy   = days - (PENTA_DAYS * mo + 2) / 5 + 1;
      mo   = mo + 3;
      // January and February belong to the next calendar year
      if (mo > MONTHS_PER_YR) begin
        yr = yr + 1;
        mo = mo - MONTHS_PER_YR;
      end
      mins           = (secs % DAY_SECS) / MINS_PER_HOUR;
      hr             = mins / MINS_PER_HOUR;
      mn             = mins % MINS_PER_HOUR;
      d.year         = yr[s2cd_pkg::YEAR_W-1:0];
      d.month        = mo[s2cd_pkg::MONTH_W-1:0];
      d.day_of_month = dy[s2cd_pkg::DOM_W-1:0];
      d.hour         = hr[s2cd_pkg::HOUR_W-1:0];
      d.minute       = mn[s2cd_pkg::MIN_W-1:0];
      return d;
    endfunction

    function void note_input(logic [31:0] secs);
      owed_dates.push_back(predict_date(secs));
    endfunction

    function int pending();
      return owed_dates.size();
    endfunction

    function void check_result(cal_date_t got);
      cal_date_t want;
      if (owed_dates.size() == 0) begin
        $error("unexpected result word: %0d-%0d-%0d %0d:%0d", got.year, got.month,
               got.day_of_month, got.hour, got.minute);
        errors++;
        return;
      end
      want = owed_dates.pop_front();
      if (got.year != want.year) begin
        $error("year: expected %0d, got %0d", want.year, got.year);
        errors++;
      end
      if (got.month != want.month) begin
        $error("month: expected %0d, got %0d", want.month, got.month);
        errors++;
      end
      if (got.day_of_month != want.day_of_month) begin
        $error("day_of_month: expected %0d, got %0d", want.day_of_month, got.day_of_month);
        errors++;
      end
      if (got.hour != want.hour) begin
        $error("hour: expected %0d, got %0d", want.hour, got.hour);
        errors++;
      end
      if (got.minute != want.minute) begin
        $error("minute: expected %0d, got %0d", want.minute, got.minute);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [s2cd_pkg::SECS_W-1:0]  in_seconds_count = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [s2cd_pkg::YEAR_W-1:0]  out_year;
  logic [s2cd_pkg::MONTH_W-1:0] out_month;
  logic [s2cd_pkg::DOM_W-1:0]   out_day_of_month;
  logic [s2cd_pkg::HOUR_W-1:0]  out_hour;
  logic [s2cd_pkg::MIN_W-1:0]   out_minute;

  bit             quiet = 1'b0;   // no idling on either side
  int             idle_run = 0;
  int             stall_left = 0;
  date_scoreboard sb = new();

  seconds_to_calendar_date dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_seconds_count (in_seconds_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute)
  );

  always #4 clk = ~clk;

  // Monitor both handshakes and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_seconds_count);
      if (out_valid && out_ready) begin
        sb.check_result('{out_year, out_month, out_day_of_month, out_hour, out_minute});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: bursts of back-pressure, none in the quiet tail
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One word offered, held until taken; optional gap in front of it
  task automatic send_word(input logic [31:0] secs);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_seconds_count <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] day_start(int unsigned day);
    return day * DAY_SECS;
  endfunction

  // Extremes of the field, leap days, 2100 as a leap year, month and year rollovers
  task automatic run_directed();
    logic [31:0] stamps[$];
    stamps = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
               day_start(D_1978_FEB28) + 32'd86399, day_start(D_1978_FEB28 + 1),
               day_start(D_1978_DEC31) + 32'd86399, day_start(D_1978_DEC31 + 1),
               day_start(D_1980_FEB29), day_start(D_1980_FEB29 + 1),
               day_start(D_2100_JAN01 - 1) + 32'd86399, day_start(D_2100_JAN01),
               day_start(D_2100_FEB29 - 1) + 32'd86399, day_start(D_2100_FEB29),
               day_start(D_2100_FEB29 + 1), day_start(D_LAST),
               32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hAAAA_AAAA, 32'h5555_5555};
    foreach (stamps[i]) send_word(stamps[i]);
  endtask

  // Mix of full-range values, day and minute edges, top of range and the 2100 leap day
  function automatic logic [31:0] random_stamp();
    logic [31:0] secs;
    case ($urandom_range(0, 4))
      0, 1: secs = $urandom;
      2: begin
        secs = day_start($urandom_range(0, D_LAST_WHOLE));
        if ($urandom_range(0, 1)) secs = secs + 32'd86399 - $urandom_range(0, 59);
        else secs = secs + $urandom_range(0, 59);
      end
      3: secs = 32'hFFFF_FFFF - $urandom_range(0, 200 * DAY_SECS);
      default: secs = day_start(D_2100_FEB29 - 2 + $urandom_range(0, 4))
                      + $urandom_range(0, DAY_SECS - 1);
    endcase
    return secs;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off once until the pipe has fully drained
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      send_word(random_stamp());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/s2cd_pkg.sv
src/s2cd_datapath.sv
src/seconds_to_calendar_date.sv
src/s2cd_checker.sv
dv/tb_top.sv
